>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks are sampled on the rising edge of clk and are off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

>>> design/rle8_pkg.sv
`timescale 1ns / 1ps

package rle8_pkg;

    localparam int DIM_W       = 13;
    localparam int AREA_W      = 26;
    localparam int SEEN_W      = 25;
    localparam int COL_W       = 16;
    localparam int ADDR_W      = 24;
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int REG_INDEX_W = 1;

    localparam int MAX_DIMENSION_DEFAULT = 4096;
    localparam int RESET_WIDTH           = 320;
    localparam int RESET_HEIGHT          = 240;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [REG_INDEX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [REG_INDEX_W-1:0] REG_HEIGHT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_END     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELTA   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 3'd4;

    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_EOI   = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

    typedef enum logic [1:0] {
        CMD_STATUS = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_EOL    = 2'd2
    } cmd_kind_t;

    // One command per accepted byte, passed from the parser to the executor.
    typedef struct packed {
        logic              restart;
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] len;
        logic [STATUS_W-1:0] status;
    } cmd_t;

    // Frame geometry derived from the configuration registers.
    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic              h_zero;
        logic [AREA_W-1:0] area;
        logic [AREA_W-1:0] base;
    } geom_t;

endpackage

>>> design/rle8_cfg.sv
`timescale 1ns / 1ps

module rle8_cfg #(
    parameter int MAX_DIMENSION = rle8_pkg::MAX_DIMENSION_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [rle8_pkg::REG_INDEX_W-1:0]   cfg_index,
    input  logic [rle8_pkg::DIM_W-1:0]         cfg_data,
    output rle8_pkg::geom_t                    geom
);

    localparam int RW = (rle8_pkg::RESET_WIDTH > MAX_DIMENSION) ?
                        MAX_DIMENSION : rle8_pkg::RESET_WIDTH;
    localparam int RH = (rle8_pkg::RESET_HEIGHT > MAX_DIMENSION) ?
                        MAX_DIMENSION : rle8_pkg::RESET_HEIGHT;
    localparam int RESET_AREA = RW * RH;
    localparam int RESET_BASE = (RH - 1) * RW;

    logic [rle8_pkg::DIM_W-1:0]  width_reg, height_reg;
    logic [rle8_pkg::AREA_W-1:0] area_reg, base_reg;
    logic [rle8_pkg::DIM_W-1:0]  data_eff, w_sel, h_sel, h_m1;
    logic [rle8_pkg::AREA_W-1:0] area_next, base_next;

    // Values above the maximum dimension are used as the maximum.
    assign data_eff = (int'(cfg_data) > MAX_DIMENSION) ?
                      rle8_pkg::DIM_W'(MAX_DIMENSION) : cfg_data;

    // The products are formed from the value being written, so they are
    // current in the same cycle as the registers.
    assign w_sel = (cfg_write && cfg_index == rle8_pkg::REG_WIDTH)  ? data_eff : width_reg;
    assign h_sel = (cfg_write && cfg_index == rle8_pkg::REG_HEIGHT) ? data_eff : height_reg;
    assign h_m1  = h_sel - 1'b1;

    assign area_next = rle8_pkg::AREA_W'(w_sel) * rle8_pkg::AREA_W'(h_sel);
    assign base_next = rle8_pkg::AREA_W'(h_m1) * rle8_pkg::AREA_W'(w_sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rle8_pkg::DIM_W'(RW);
            height_reg <= rle8_pkg::DIM_W'(RH);
            area_reg   <= rle8_pkg::AREA_W'(RESET_AREA);
            base_reg   <= rle8_pkg::AREA_W'(RESET_BASE);
        end
        else if (cfg_write)
        begin
            width_reg  <= w_sel;
            height_reg <= h_sel;
            area_reg   <= area_next;
            base_reg   <= base_next;
        end
    end

    assign geom.width  = width_reg;
    assign geom.h_zero = (height_reg == '0);
    assign geom.area   = area_reg;
    assign geom.base   = base_reg;

endmodule

>>> design/rle8_front.sv
`timescale 1ns / 1ps

module rle8_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         frame_start,
    input  logic [rle8_pkg::BYTE_W-1:0]  code_byte,
    input  rle8_pkg::geom_t              geom,
    output rle8_pkg::cmd_t               cmd
);

    typedef enum logic [7:0] {
        PH_COUNT     = 8'b0000_0001,
        PH_VALUE     = 8'b0000_0010,
        PH_ESCAPE    = 8'b0000_0100,
        PH_LITERAL   = 8'b0000_1000,
        PH_PAD       = 8'b0001_0000,
        PH_END_IMAGE = 8'b0010_0000,
        PH_END_DELTA = 8'b0100_0000,
        PH_END_LIMIT = 8'b1000_0000
    } phase_t;

    localparam logic [rle8_pkg::SEEN_W-1:0] SEEN_MAX = {rle8_pkg::SEEN_W{1'b1}};

    phase_t                         phase_reg, phase_next, ph;
    logic [rle8_pkg::BYTE_W-1:0]    pending_reg, pending_next, pend;
    logic [rle8_pkg::BYTE_W-1:0]    literal_reg, literal_next, lit, lit_dec;
    logic [rle8_pkg::SEEN_W-1:0]    seen_reg, seen_next, seen;

    // A frame start clears the parser before its own byte is looked at.
    assign ph   = frame_start ? PH_COUNT : phase_reg;
    assign pend = frame_start ? '0 : pending_reg;
    assign lit  = frame_start ? '0 : literal_reg;
    assign seen = frame_start ? '0 : seen_reg;
    assign lit_dec = (lit != '0) ? lit - 1'b1 : lit;

    always_comb
    begin
        phase_next   = ph;
        pending_next = pend;
        literal_next = lit;
        seen_next    = seen;
        cmd.restart  = frame_start;
        cmd.kind     = rle8_pkg::CMD_STATUS;
        cmd.value    = '0;
        cmd.len      = '0;
        cmd.status   = rle8_pkg::ST_OK;
        case (ph)
            PH_END_IMAGE: cmd.status = rle8_pkg::ST_END;
            PH_END_DELTA: cmd.status = rle8_pkg::ST_DELTA;
            PH_END_LIMIT: cmd.status = rle8_pkg::ST_LIMIT;
            default:
            begin
                // The source limit is area+1 bytes and is checked only at a count byte.
                if (ph == PH_COUNT && rle8_pkg::AREA_W'(seen) > geom.area)
                begin
                    phase_next = PH_END_LIMIT;
                    cmd.status = rle8_pkg::ST_LIMIT;
                end
                else
                begin
                    seen_next = (seen != SEEN_MAX) ? seen + 1'b1 : seen;
                    case (ph)
                        PH_COUNT:
                        begin
                            if (code_byte == rle8_pkg::ESC_EOL)
                            begin
                                phase_next = PH_ESCAPE;
                            end
                            else
                            begin
                                pending_next = code_byte;
                                phase_next   = PH_VALUE;
                            end
                        end
                        PH_VALUE:
                        begin
                            cmd.kind   = rle8_pkg::CMD_WRITE;
                            cmd.value  = code_byte;
                            cmd.len    = pend;
                            phase_next = PH_COUNT;
                        end
                        PH_ESCAPE:
                        begin
                            if (code_byte == rle8_pkg::ESC_EOL)
                            begin
                                cmd.kind   = rle8_pkg::CMD_EOL;
                                phase_next = PH_COUNT;
                            end
                            else if (code_byte == rle8_pkg::ESC_EOI)
                            begin
                                cmd.status = rle8_pkg::ST_END;
                                phase_next = PH_END_IMAGE;
                            end
                            else if (code_byte == rle8_pkg::ESC_DELTA)
                            begin
                                cmd.status = rle8_pkg::ST_DELTA;
                                phase_next = PH_END_DELTA;
                            end
                            else
                            begin
                                pending_next = code_byte;
                                literal_next = code_byte;
                                phase_next   = PH_LITERAL;
                            end
                        end
                        PH_LITERAL:
                        begin
                            cmd.kind     = rle8_pkg::CMD_WRITE;
                            cmd.value    = code_byte;
                            cmd.len      = rle8_pkg::BYTE_W'(1);
                            literal_next = lit_dec;
                            // Odd literal lengths are followed by one pad byte.
                            if (lit_dec == '0)
                            begin
                                phase_next = pend[0] ? PH_PAD : PH_COUNT;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_COUNT;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_COUNT;
            pending_reg <= '0;
            literal_reg <= '0;
            seen_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            literal_reg <= literal_next;
            seen_reg    <= seen_next;
        end
    end

endmodule

>>> design/rle8_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rle8_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rle8_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output rle8_pkg::cmd_t  head_cmd,
    output logic            full,
    output logic            empty
);

    localparam int QPTR_W = rle8_pkg::QPTR_W;
    localparam int QCNT_W = rle8_pkg::QCNT_W;

    rle8_pkg::cmd_t       entry_reg [rle8_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]    count_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(rle8_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = (count_reg == QCNT_W'(rle8_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, push, !full || pop, "command pushed into a full queue")
    `ASSERT_IMPLIES(a_no_underflow, pop, !empty, "command popped from an empty queue")

endmodule

>>> design/rle8_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rle8_back #(
    parameter int MAX_DIMENSION = rle8_pkg::MAX_DIMENSION_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rle8_pkg::geom_t                geom,
    input  rle8_pkg::cmd_t                 head_cmd,
    input  logic                           empty,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           write_valid,
    output logic [rle8_pkg::ADDR_W-1:0]    pixel_address,
    output logic [rle8_pkg::BYTE_W-1:0]    pixel_value,
    output logic [rle8_pkg::BYTE_W-1:0]    run_length,
    output logic [rle8_pkg::STATUS_W-1:0]  status
);

    localparam int COL_W  = rle8_pkg::COL_W;
    localparam int AREA_W = rle8_pkg::AREA_W;
    localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};

    localparam int RW = (rle8_pkg::RESET_WIDTH > MAX_DIMENSION) ?
                        MAX_DIMENSION : rle8_pkg::RESET_WIDTH;
    localparam int RH = (rle8_pkg::RESET_HEIGHT > MAX_DIMENSION) ?
                        MAX_DIMENSION : rle8_pkg::RESET_HEIGHT;
    localparam int RESET_BASE = (RH - 1) * RW;

    logic [AREA_W-1:0]             row_base_reg, row_base_next, rb;
    logic                          row_out_reg, row_out_next, rout;
    logic [COL_W-1:0]              column_reg, column_next, col;
    logic [COL_W:0]                endcol;
    logic                          outside;
    logic [AREA_W-1:0]             addr_sum;

    logic                          out_valid_reg;
    logic                          write_valid_reg, write_valid_next;
    logic [rle8_pkg::ADDR_W-1:0]   address_reg, address_next;
    logic [rle8_pkg::BYTE_W-1:0]   value_reg, value_next;
    logic [rle8_pkg::BYTE_W-1:0]   length_reg, length_next;
    logic [rle8_pkg::STATUS_W-1:0] status_reg, status_next;

    // A command moves to the output register whenever that register is free
    // or its beat is taken in the same cycle.
    assign pop = !empty && (!out_valid_reg || !out_stall);

    // A restart puts the frame back at the first column of the last row.
    assign rb   = head_cmd.restart ? geom.base : row_base_reg;
    assign rout = head_cmd.restart ? geom.h_zero : row_out_reg;
    assign col  = head_cmd.restart ? '0 : column_reg;

    assign endcol   = {1'b0, col} + (COL_W + 1)'(head_cmd.len);
    assign outside  = rout || (endcol > (COL_W + 1)'(geom.width));
    assign addr_sum = rb + AREA_W'(col);

    always_comb
    begin
        row_base_next    = rb;
        row_out_next     = rout;
        column_next      = col;
        write_valid_next = 1'b0;
        address_next     = '0;
        value_next       = '0;
        length_next      = '0;
        status_next      = head_cmd.status;
        case (head_cmd.kind)
            rle8_pkg::CMD_WRITE:
            begin
                value_next  = head_cmd.value;
                length_next = head_cmd.len;
                column_next = endcol[COL_W] ? COL_MAX : endcol[COL_W-1:0];
                if (outside)
                begin
                    status_next = rle8_pkg::ST_OUTSIDE;
                end
                else
                begin
                    write_valid_next = 1'b1;
                    address_next     = addr_sum[rle8_pkg::ADDR_W-1:0];
                    status_next      = rle8_pkg::ST_OK;
                end
            end
            rle8_pkg::CMD_EOL:
            begin
                column_next = '0;
                // Once the row drops below row 0 it stays outside the frame.
                if (!rout)
                begin
                    if (rb < AREA_W'(geom.width))
                    begin
                        row_out_next = 1'b1;
                    end
                    else
                    begin
                        row_base_next = rb - AREA_W'(geom.width);
                    end
                end
            end
            default:
            begin
                status_next = head_cmd.status;
            end
        endcase
    end

    // Bytes ahead of the first frame start are placed in the last row of the
    // reset frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_base_reg  <= AREA_W'(RESET_BASE);
            row_out_reg   <= 1'b0;
            column_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                row_base_reg <= row_base_next;
                row_out_reg  <= row_out_next;
                column_reg   <= column_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            write_valid_reg <= write_valid_next;
            address_reg     <= address_next;
            value_reg       <= value_next;
            length_reg      <= length_next;
            status_reg      <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_valid   = write_valid_reg;
    assign pixel_address = address_reg;
    assign pixel_value   = value_reg;
    assign run_length    = length_reg;
    assign status        = status_reg;

    `ASSERT_IMPLIES(a_write_ok, out_valid_reg && write_valid_reg, status_reg == rle8_pkg::ST_OK && length_reg != '0, "bad pixel write")
    `ASSERT_NEXT(a_row_sticky, row_out_reg && !(pop && head_cmd.restart), row_out_reg, "row left the outside")

endmodule

>>> design/rle8_bitmap_decoder.sv
`timescale 1ns / 1ps

// RLE8 bitmap decoder. Takes one compressed byte per beat (frame_start marks
// the first byte of a frame and restarts the parser) and gives exactly one
// result beat per byte: a pixel run descriptor (row base plus column, value,
// length) or a status, rows filled bottom row first. The block sustains one
// byte per clock while out_stall is low. The accepting edge writes a byte's
// command into the four-entry command queue; from there it moves through the
// address and frame-bounds unit into the output register. While the output
// is stalled, the output register and the queue together take five bytes
// before in_stall rises. The user is to write image_width and image_height
// (index 0 and 1) only while the block is idle; the block does not enforce
// this. They take effect for the next byte.
module rle8_bitmap_decoder #(
    parameter int MAX_DIMENSION = rle8_pkg::MAX_DIMENSION_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [rle8_pkg::REG_INDEX_W-1:0]   cfg_index,
    input  logic [rle8_pkg::DIM_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               frame_start,
    input  logic [rle8_pkg::BYTE_W-1:0]        code_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               write_valid,
    output logic [rle8_pkg::ADDR_W-1:0]        pixel_address,
    output logic [rle8_pkg::BYTE_W-1:0]        pixel_value,
    output logic [rle8_pkg::BYTE_W-1:0]        run_length,
    output logic [rle8_pkg::STATUS_W-1:0]      status
);

    rle8_pkg::geom_t geom;
    rle8_pkg::cmd_t  front_cmd, head_cmd;
    logic            accept, pop, full, empty;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    rle8_cfg #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    rle8_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .frame_start (frame_start),
        .code_byte   (code_byte),
        .geom        (geom),
        .cmd         (front_cmd)
    );

    rle8_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (full),
        .empty    (empty)
    );

    rle8_back #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .geom          (geom),
        .head_cmd      (head_cmd),
        .empty         (empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_valid   (write_valid),
        .pixel_address (pixel_address),
        .pixel_value   (pixel_value),
        .run_length    (run_length),
        .status        (status)
    );

endmodule
